### hw/rtl/wsd_pkg.sv
// Shared types and fixed field widths of the work-stealing distributor.
package wsd_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_STEAL = 2'd2,
    FUNC_CLEAR = 2'd3
  } wsd_func_t;

  localparam int WID_W       = 3;
  localparam int ITEM_W      = 64;
  localparam int TOTAL_W     = 14;
  localparam int STEAL_W     = 64;
  localparam int CFG_W       = 4;
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_TUSER_W = 1;

  localparam logic [CFG_W-1:0] WC_RESET = 4'd8;

endpackage

### hw/rtl/work_stealing_distributor_top.sv
// Top level of the work-stealing distributor: deque pointers, victim pick and result stage.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready   | tuser: func; tdata: worker_id, item_in
//  out_    | master    | out_tvalid/out_tready | tuser: ok; tdata: item_out, total_items,
//          |           |                       |        all_empty, steals_done
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_data: worker_count
//
// Each request passes through accept, execute (pointer update, victim pick and at most one
// ring memory access), then load of the result register from the memory read data.
// A request is accepted while an earlier result still waits; its load stalls until the
// output register is taken. Reset clears all pointers, the steal count and the item
// total with no clearing pass; the ring memory itself is not cleared.
// cfg_ready is always high.
module work_stealing_distributor_top #(
  parameter int DEQUE_DEPTH = 1024,
  parameter int MAX_WORKERS = 8,
  parameter int ITEM_WIDTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tuser: func [1:0]
  input  logic [wsd_pkg::FUNC_W-1:0]        in_tuser,
  // tdata: worker_id [2:0], item_in [66:3], zero pad [71:67]
  input  logic [wsd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tuser: ok [0]
  output logic [wsd_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // tdata: item_out [63:0], total_items [77:64], all_empty [78],
  //        steals_done [142:79], zero pad [143]
  output logic [wsd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [wsd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  import wsd_pkg::*;

  localparam int PTR_MOD = 2 * DEQUE_DEPTH;
  localparam int PW      = $clog2(PTR_MOD);
  localparam int IW      = $clog2(DEQUE_DEPTH);
  localparam int WW      = $clog2(MAX_WORKERS);
  localparam int NW      = CFG_W + 1;
  localparam int TW      = $clog2(MAX_WORKERS * DEQUE_DEPTH + 1);
  localparam int MEM_D   = MAX_WORKERS * (2 ** IW);
  localparam int AW      = $clog2(MEM_D);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DATA} state_t;

  // Pointer helpers, modulo twice the deque depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(PTR_MOD - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(PTR_MOD - 1) : p - PW'(1);
  endfunction

  function automatic logic [IW-1:0] ptr_idx(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= PW'(DEQUE_DEPTH)) ? p - PW'(DEQUE_DEPTH) : p;
    ptr_idx = r[IW-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     wc_r;
  wsd_func_t            func_r, func_nxt;
  logic [WID_W-1:0]     wid_r, wid_nxt;
  logic [ITEM_W-1:0]    item_r, item_nxt;
  logic [PW-1:0]        top_r [MAX_WORKERS];
  logic [PW-1:0]        top_nxt [MAX_WORKERS];
  logic [PW-1:0]        bot_r [MAX_WORKERS];
  logic [PW-1:0]        bot_nxt [MAX_WORKERS];
  logic [STEAL_W-1:0]   steal_r, steal_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic                 ok_r, ok_nxt;
  logic                 hit_r, hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [ITEM_W-1:0]    out_item_r, out_item_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [STEAL_W-1:0]   out_steal_r, out_steal_nxt;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;

  logic [NW-1:0]  n_act;
  logic [WW-1:0]  own;
  logic [PW-1:0]  own_top, own_bot, own_bot_dec;
  logic [PW:0]    own_fill;
  logic           own_empty, own_full, bad_wid;
  logic           vic_found;
  logic [WW-1:0]  vic;

  // Effective worker count: zero acts as one, overlarge values saturate
  always_comb begin
    if (wc_r == '0) begin
      n_act = NW'(1);
    end else if ({1'b0, wc_r} > NW'(MAX_WORKERS)) begin
      n_act = NW'(MAX_WORKERS);
    end else begin
      n_act = {1'b0, wc_r};
    end
  end

  assign own         = WW'(wid_r);
  assign own_top     = top_r[own];
  assign own_bot     = bot_r[own];
  assign own_bot_dec = ptr_dec(own_bot);
  assign own_fill    = (own_bot >= own_top) ? {1'b0, own_bot} - {1'b0, own_top}
                                            : {1'b0, own_bot} + (PW+1)'(PTR_MOD)
                                              - {1'b0, own_top};
  assign own_empty   = (own_bot == own_top);
  assign own_full    = (own_fill == (PW+1)'(DEQUE_DEPTH));
  assign bad_wid     = (NW'(wid_r) >= n_act);

  // Rotated priority pick: first non-empty deque after the requester, wrapping at n_act
  always_comb begin
    logic [NW-1:0] cand;
    vic_found = 1'b0;
    vic       = '0;
    for (int off = 1; off < MAX_WORKERS; off++) begin
      cand = NW'(wid_r) + NW'(off);
      if (cand >= n_act) begin
        cand = cand - n_act;
      end
      if (!vic_found && (NW'(off) < n_act) &&
          (top_r[cand[WW-1:0]] != bot_r[cand[WW-1:0]])) begin
        vic_found = 1'b1;
        vic       = cand[WW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    wid_nxt       = wid_r;
    item_nxt      = item_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    steal_nxt     = steal_r;
    total_nxt     = total_r;
    ok_nxt        = ok_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_item_nxt  = out_item_r;
    out_total_nxt = out_total_r;
    out_empty_nxt = out_empty_r;
    out_steal_nxt = out_steal_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = {own, ptr_idx(own_bot)};
    mem_raddr     = {own, ptr_idx(own_bot_dec)};

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = wsd_func_t'(in_tuser);
          wid_nxt   = in_tdata[WID_W-1:0];
          item_nxt  = in_tdata[WID_W +: ITEM_W];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ok_nxt    = 1'b0;
        hit_nxt   = 1'b0;
        state_nxt = S_DATA;
        if (func_r == FUNC_CLEAR) begin
          for (int i = 0; i < MAX_WORKERS; i++) begin
            top_nxt[i] = '0;
            bot_nxt[i] = '0;
          end
          total_nxt = '0;
          ok_nxt    = 1'b1;
        end else if (!bad_wid) begin
          if (func_r == FUNC_PUSH) begin
            if (!own_full) begin
              mem_we       = 1'b1;
              bot_nxt[own] = ptr_inc(own_bot);
              total_nxt    = total_r + TW'(1);
              ok_nxt       = 1'b1;
            end
          end else if (func_r == FUNC_POP && !own_empty) begin
            mem_re       = 1'b1;
            bot_nxt[own] = own_bot_dec;
            total_nxt    = total_r - TW'(1);
            ok_nxt       = 1'b1;
            hit_nxt      = 1'b1;
          end else if (vic_found) begin
            mem_re       = 1'b1;
            mem_raddr    = {vic, ptr_idx(top_r[vic])};
            top_nxt[vic] = ptr_inc(top_r[vic]);
            steal_nxt    = steal_r + STEAL_W'(1);
            total_nxt    = total_r - TW'(1);
            ok_nxt       = 1'b1;
            hit_nxt      = 1'b1;
          end
        end
      end
      S_DATA: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_item_nxt  = hit_r ? ITEM_W'(mem_rdata) : '0;
          out_total_nxt = TOTAL_W'(total_r);
          out_empty_nxt = (total_r == '0);
          out_steal_nxt = steal_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= WC_RESET;
      steal_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        top_r[i] <= '0;
        bot_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      steal_r     <= steal_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      if (cfg_valid) begin
        wc_r <= cfg_data;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    wid_r       <= wid_nxt;
    item_r      <= item_nxt;
    ok_r        <= ok_nxt;
    hit_r       <= hit_nxt;
    out_ok_r    <= out_ok_nxt;
    out_item_r  <= out_item_nxt;
    out_total_r <= out_total_nxt;
    out_empty_r <= out_empty_nxt;
    out_steal_r <= out_steal_nxt;
  end

  wsd_ring #(
    .DEPTH (MEM_D),
    .DW    (ITEM_WIDTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (item_r[ITEM_WIDTH-1:0]),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {1'b0, out_steal_r, out_empty_r, out_total_r, out_item_r};

  // The ring memory is never read and written in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
    else $error("ring read and write issued together");

  // Stored item count stays within the total capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(MAX_WORKERS * DEQUE_DEPTH))
    else $error("item total beyond capacity");

  // Steal count moves by at most one per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (steal_r == $past(steal_r)) || (steal_r == $past(steal_r) + STEAL_W'(1)))
    else $error("steal count jumped");

  // A failed request returns a zero item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_item_r == '0))
    else $error("failed request carries an item");

endmodule

### hw/rtl/wsd_ring.sv
// Ring item store: one write port, one read port with registered read data.
module wsd_ring #(
  parameter int DEPTH = 8192,
  parameter int DW    = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
